### rtl/ofdmcp_pkg.sv
`timescale 1ns / 1ps

package ofdmcp_pkg;

   typedef enum logic [2:0] {
      OP_DATA_PATTERN  = 3'd0,
      OP_PILOT_PATTERN = 3'd1,
      OP_DATA_SYMBOL   = 3'd2,
      OP_PILOT_SYMBOL  = 3'd3,
      OP_EMIT          = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ROLE_ZERO  = 2'd0,
      ROLE_DATA  = 2'd1,
      ROLE_PILOT = 2'd2
   } role_type;

   localparam int SLOT_W        = 7;
   localparam int CARRIER_NUM_W = 8;
   localparam int SAMPLE_W      = 16;
   localparam int LEN_W         = 8;
   localparam int OP_W          = 3;
   localparam int CSR_IDX_W     = 1;
   localparam int REQ_TDATA_W   = 48;
   localparam int RSP_TDATA_W   = 2 * SAMPLE_W;

   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX_LEN  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POSTFIX_LEN = 1'd1;

   localparam logic [LEN_W-1:0] PREFIX_LEN_RESET  = 8'd18;
   localparam logic [LEN_W-1:0] POSTFIX_LEN_RESET = 8'd2;

   typedef struct packed {
      role_type            role;
      logic [SLOT_W-1:0]   slot;
   } map_entry_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] im;
      logic signed [SAMPLE_W-1:0] re;
   } sample_type;

   typedef struct packed {
      logic              data_we;
      logic              pilot_we;
      logic              rd_en;
      logic [SLOT_W-1:0] slot;
      sample_type        value;
   } slot_req_type;

endpackage

### rtl/ofdmcp_map.sv
`timescale 1ns / 1ps

module ofdmcp_map
   import ofdmcp_pkg::*;
#(
   parameter int  CARRIERS = 128,
   localparam int CW       = $clog2(CARRIERS)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [CW-1:0] rd_addr,
   input  logic          wr_en,
   input  logic [CW-1:0] wr_addr,
   input  map_entry_type wr_data,
   output map_entry_type rd_data,
   output logic          busy
);

   map_entry_type mem [CARRIERS];

   map_entry_type rd_ff;
   map_entry_type fwd_data_ff;
   logic          fwd_ff;
   logic          clearing_ff, clearing_in;
   logic [CW-1:0] clr_idx_ff, clr_idx_in;

   logic          we;
   logic [CW-1:0] waddr;
   map_entry_type wdata;

   always_comb begin
      we          = clearing_ff | wr_en;
      waddr       = clearing_ff ? clr_idx_ff : wr_addr;
      wdata       = wr_data;
      if (clearing_ff) begin
         wdata.role = ROLE_ZERO;
         wdata.slot = '0;
      end
      clearing_in = clearing_ff && (clr_idx_ff != CW'(CARRIERS - 1));
      clr_idx_in  = clearing_ff ? clr_idx_ff + CW'(1) : clr_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   // write-first forwarding when the same entry is read and written in one cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rd_ff       <= mem[rd_addr];
         fwd_ff      <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : rd_ff;
   assign busy    = clearing_ff;

endmodule

### rtl/ofdmcp_slots.sv
`timescale 1ns / 1ps

module ofdmcp_slots
   import ofdmcp_pkg::*;
#(
   parameter int  DATA_SLOTS  = 128,
   parameter int  PILOT_SLOTS = 16,
   localparam int DW          = (DATA_SLOTS > 1) ? $clog2(DATA_SLOTS) : 1,
   localparam int PW          = (PILOT_SLOTS > 1) ? $clog2(PILOT_SLOTS) : 1
) (
   input  logic         clock,
   input  slot_req_type req,
   output sample_type   data_rd,
   output sample_type   pilot_rd
);

   sample_type data_mem  [DATA_SLOTS];
   sample_type pilot_mem [PILOT_SLOTS];

   sample_type data_rd_ff;
   sample_type pilot_rd_ff;

   logic [DW-1:0] didx;
   logic [PW-1:0] pidx;

   assign didx = DW'(req.slot);
   assign pidx = PW'(req.slot);

   always_ff @(posedge clock) begin
      if (req.data_we) begin
         data_mem[didx] <= req.value;
      end
      if (req.pilot_we) begin
         pilot_mem[pidx] <= req.value;
      end
      if (req.rd_en) begin
         data_rd_ff  <= data_mem[didx];
         pilot_rd_ff <= pilot_mem[pidx];
      end
   end

   assign data_rd  = data_rd_ff;
   assign pilot_rd = pilot_rd_ff;

endmodule

### rtl/ofdm_subcarrier_mapper_cyclic_prefix.sv
`timescale 1ns / 1ps
// an emit transaction's sample shows on rsp after the stage 1 and output registers
// throughput: one transaction per cycle while req_tready is high; the carrier map read
// and the slot read are two pipelined memory stages; req_tready drops while the output
// register is full and rsp_tready is low; reset: synchronous; the carrier map is then
// cleared one entry per cycle, req_tready low; prefix_len resets to 18, postfix_len to 2

module ofdm_subcarrier_mapper_cyclic_prefix
   import ofdmcp_pkg::*;
#(
   parameter int  CARRIERS    = 128,
   parameter int  DATA_SLOTS  = 128,
   parameter int  PILOT_SLOTS = 16,
   localparam int CW          = $clog2(CARRIERS),
   localparam int PW          = $clog2(3 * CARRIERS + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // slot_index, carrier_number, sample_re, sample_im
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // opcode
   input  logic [OP_W-1:0]        req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // out_re, out_im
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [LEN_W-1:0]       csr_wdata
);

   logic [LEN_W-1:0] prefix_len_ff, postfix_len_ff;
   logic [PW-1:0]    pos_ff, pos_in;

   // stage 1
   logic              s1_valid_ff;
   op_type            s1_op_ff;
   logic              s1_ok_ff;
   logic              s1_last_ff;
   logic [CW-1:0]     s1_carrier_ff;
   logic [SLOT_W-1:0] s1_slot_ff;
   sample_type        s1_value_ff;

   // output register
   logic     rsp_valid_ff;
   logic     rsp_last_ff;
   role_type rsp_src_ff;

   op_type                   in_op;
   logic [SLOT_W-1:0]        in_slot;
   logic [CARRIER_NUM_W-1:0] in_cn;
   sample_type               in_value;

   logic          adv, accept, map_busy;
   logic          cn_ok, data_slot_ok, pilot_slot_ok, s0_ok;
   logic [PW-1:0] pre_len, post_len, total, p;
   logic [CW-1:0] emit_carrier, pat_carrier, map_rd_addr;
   logic          emit_last;

   map_entry_type map_rd, map_wr_data;
   logic          map_wr_en;
   slot_req_type  slot_req;
   sample_type    data_rd, pilot_rd, rsp_value;

   assign in_op       = op_type'(req_tuser);
   assign in_slot     = req_tdata[6:0];
   assign in_cn       = req_tdata[14:7];
   assign in_value.re = req_tdata[30:15];
   assign in_value.im = req_tdata[46:31];

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv && !map_busy;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      pre_len  = (32'(prefix_len_ff) > 32'(CARRIERS)) ? PW'(CARRIERS) : PW'(prefix_len_ff);
      post_len = (32'(postfix_len_ff) > 32'(CARRIERS)) ? PW'(CARRIERS) : PW'(postfix_len_ff);
      total    = pre_len + PW'(CARRIERS) + post_len;
      p        = (pos_ff >= total) ? '0 : pos_ff;
      if (p < pre_len) begin
         emit_carrier = CW'(PW'(CARRIERS) - pre_len + p);
      end else if (p < pre_len + PW'(CARRIERS)) begin
         emit_carrier = CW'(p - pre_len);
      end else begin
         emit_carrier = CW'(p - pre_len - PW'(CARRIERS));
      end
      emit_last = (p == total - PW'(1));
      pos_in    = emit_last ? '0 : p + PW'(1);

      cn_ok         = (in_cn != '0) && (32'(in_cn) <= 32'(CARRIERS));
      data_slot_ok  = 32'(in_slot) < 32'(DATA_SLOTS);
      pilot_slot_ok = 32'(in_slot) < 32'(PILOT_SLOTS);
      pat_carrier   = CW'(in_cn - CARRIER_NUM_W'(1));

      case (in_op)
         OP_DATA_PATTERN:  s0_ok = cn_ok && data_slot_ok;
         OP_PILOT_PATTERN: s0_ok = cn_ok && pilot_slot_ok;
         OP_DATA_SYMBOL:   s0_ok = data_slot_ok;
         OP_PILOT_SYMBOL:  s0_ok = pilot_slot_ok;
         OP_EMIT:          s0_ok = 1'b1;
         default:          s0_ok = 1'b0;
      endcase

      map_rd_addr = (in_op == OP_EMIT) ? emit_carrier : pat_carrier;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_len_ff  <= PREFIX_LEN_RESET;
         postfix_len_ff <= POSTFIX_LEN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PREFIX_LEN:  prefix_len_ff  <= csr_wdata;
            CSR_POSTFIX_LEN: postfix_len_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept && (in_op == OP_EMIT)) begin
            pos_ff <= pos_in;
         end
         if (adv) begin
            s1_valid_ff  <= accept;
            rsp_valid_ff <= s1_valid_ff && (s1_op_ff == OP_EMIT);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff      <= in_op;
         s1_ok_ff      <= s0_ok;
         s1_last_ff    <= emit_last;
         s1_carrier_ff <= pat_carrier;
         s1_slot_ff    <= in_slot;
         s1_value_ff   <= in_value;
      end
      if (adv) begin
         rsp_last_ff <= s1_last_ff;
         rsp_src_ff  <= map_rd.role;
      end
   end

   // stage 1: map update for pattern entries, slot access for symbols and emits
   always_comb begin
      map_wr_en = 1'b0;
      map_wr_data.role = (s1_op_ff == OP_PILOT_PATTERN) ? ROLE_PILOT : ROLE_DATA;
      map_wr_data.slot = s1_slot_ff;
      if (adv && s1_valid_ff && s1_ok_ff) begin
         case (s1_op_ff)
            OP_DATA_PATTERN:  map_wr_en = (map_rd.role != ROLE_PILOT);
            OP_PILOT_PATTERN: map_wr_en = 1'b1;
            default:          map_wr_en = 1'b0;
         endcase
      end

      slot_req.data_we  = adv && s1_valid_ff && s1_ok_ff && (s1_op_ff == OP_DATA_SYMBOL);
      slot_req.pilot_we = adv && s1_valid_ff && s1_ok_ff && (s1_op_ff == OP_PILOT_SYMBOL);
      slot_req.rd_en    = adv && s1_valid_ff && (s1_op_ff == OP_EMIT);
      slot_req.slot     = (s1_op_ff == OP_EMIT) ? map_rd.slot : s1_slot_ff;
      slot_req.value    = s1_value_ff;
   end

   ofdmcp_map #(
      .CARRIERS (CARRIERS)
   ) u_map (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (map_rd_addr),
      .wr_en   (map_wr_en),
      .wr_addr (s1_carrier_ff),
      .wr_data (map_wr_data),
      .rd_data (map_rd),
      .busy    (map_busy)
   );

   ofdmcp_slots #(
      .DATA_SLOTS  (DATA_SLOTS),
      .PILOT_SLOTS (PILOT_SLOTS)
   ) u_slots (
      .clock    (clock),
      .req      (slot_req),
      .data_rd  (data_rd),
      .pilot_rd (pilot_rd)
   );

   always_comb begin
      case (rsp_src_ff)
         ROLE_PILOT: rsp_value = pilot_rd;
         ROLE_DATA:  rsp_value = data_rd;
         default:    rsp_value = '0;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value;
   assign rsp_tlast  = rsp_last_ff;

endmodule
